### sv/adsr_pkg.sv
// ADSR envelope generator package: widths, register indexes, command and phase codes.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

	localparam int LEVEL_WIDTH_DEF  = 24;
	localparam int SAMPLE_WIDTH_DEF = 24;

	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int MULT_W     = 24;
	localparam int MULT_FRAC  = 24;
	localparam int BASE_W     = 24;
	localparam int LVLREG_W   = 23;
	localparam int DIGIT      = 8;
	localparam int PHASE_W    = 3;
	localparam int CMD_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_MULT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_BASE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_MULT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_BASE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MULT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_BASE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL     = 3'd7;

	localparam logic [LVLREG_W-1:0] SUSTAIN_RST = 23'd2097152;
	localparam logic [LVLREG_W-1:0] MIN_RST     = 23'd42;

	localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
	localparam logic [CMD_W-1:0] CMD_NOTE_ON   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_NOTE_OFF  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RST_LEVEL = 2'd3;

	localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
	localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

endpackage

`default_nettype wire

### sv/adsr_envelope_generator_top.sv
// ADSR envelope generator top level: sequencer, config registers, digit-serial multiplier.
// Depends on adsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   s_* channel takes one command item: tuser = cmd, tdata = sample_in.
//   m_* channel returns one result item per command: level, sample_out, phase, active.
//   cfg_we/cfg_addr/cfg_wdata write one envelope register per cycle; the user writes
//   them only while idle, which the block itself does not enforce.
// Command paths:
//   note on, note off, reset level, tick in idle: no product; straight to ST_FIN.
//   tick in sustain: one sample product; in attack, decay, release: level, then sample product.
//   NSTEP = ceil(max(25, SAMPLE_WIDTH) / 8) digits; 4 at the default widths. One shared
//   8-bit-digit serial multiplier forms both products.
//   One item is in work at a time; s_tready is high only between items.
// Reset: phase idle, level 0, registers to their reset values, output empty.
// Stall: a result waits in the output register; the next item can be accepted, and its
//   result is held inside until the output register frees up.
module adsr_envelope_generator_top
	import adsr_pkg::*;
#(
	parameter int LEVEL_WIDTH  = LEVEL_WIDTH_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  wire logic                                               clk,
	input  wire logic                                               arst_n,
	input  wire logic                                               s_tvalid,
	output      logic                                               s_tready,
	// sample_in
	input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]                  s_tdata,
	// cmd
	input  wire logic [CMD_W-1:0]                                   s_tuser,
	output      logic                                               m_tvalid,
	input  wire logic                                               m_tready,
	// level, sample_out, phase, active
	output      logic [((LEVEL_WIDTH+SAMPLE_WIDTH+PHASE_W+1+7)/8)*8-1:0] m_tdata,
	input  wire logic                                               cfg_we,
	input  wire logic [CFG_IDX_W-1:0]                               cfg_addr,
	input  wire logic [CFG_W-1:0]                                   cfg_wdata
);

	localparam int LW    = LEVEL_WIDTH;
	localparam int SW    = SAMPLE_WIDTH;
	localparam int D     = DIGIT;
	localparam int MBW   = (MULT_W + 1 > SW) ? MULT_W + 1 : SW;
	localparam int NB    = ((MBW + D - 1) / D) * D;
	localparam int NSTEP = NB / D;
	localparam int CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
	localparam int HW    = LW + D + 1;
	localparam int RW    = HW + NB;
	localparam int XW    = ((LW > BASE_W) ? LW : BASE_W) + 2;
	localparam int OW    = ((LW + SW + PHASE_W + 1 + 7) / 8) * 8;

	localparam logic signed [XW-1:0] LVL_MAX = {{(XW-LW+1){1'b0}}, {(LW-1){1'b1}}};
	localparam logic signed [XW-1:0] LVL_MIN = ~LVL_MAX;
	localparam logic signed [XW-1:0] LVL_ONE = XW'(1) << (LW - 2);
	localparam logic signed [SW+2:0] SMP_MAX = {4'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW+2:0] SMP_MIN = ~SMP_MAX;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_RND1 = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_MUL2 = 3'd4;
	localparam logic [2:0] ST_RND2 = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [MULT_W-1:0]         attack_mult_q, decay_mult_q, release_mult_q;
	logic [BASE_W-1:0]         attack_base_q, decay_base_q, release_base_q;
	logic [LVLREG_W-1:0]       sustain_q, min_q;

	logic [2:0]                st_q;
	logic [CW-1:0]             step_q;
	logic [PHASE_W-1:0]        phase_q;
	logic signed [LW-1:0]      level_q;
	logic [SW-1:0]             sample_q;
	logic [RW-1:0]             r_q;
	logic signed [LW:0]        rnd_q;
	logic signed [SW-1:0]      sout_q;
	logic                      m_tvalid_q;
	logic [OW-1:0]             m_tdata_q;

	logic                      accept;
	logic [CMD_W-1:0]          cmd;
	logic [SW-1:0]             smp_in;
	logic [MULT_W-1:0]         mult_sel;
	logic [BASE_W-1:0]         base_sel;
	logic signed [XW-1:0]      level_x, min_x, minl_x, sus_x, suss_x, v_x, v_sat;
	logic                      last_step;
	logic [D-1:0]              dig;
	logic signed [D:0]         dig_s;
	logic signed [HW-1:0]      pp, hi_sum;
	logic [RW-1:0]             r_step;
	logic signed [SW+2:0]      s_rnd, s_sat;
	logic                      out_free;

	assign cmd      = s_tuser;
	assign smp_in   = s_tdata[SW-1:0];
	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		case (phase_q)
			PH_ATTACK: begin
				mult_sel = attack_mult_q;
				base_sel = attack_base_q;
			end
			PH_DECAY: begin
				mult_sel = decay_mult_q;
				base_sel = decay_base_q;
			end
			default: begin
				mult_sel = release_mult_q;
				base_sel = release_base_q;
			end
		endcase
	end

	// level-range views of the registers
	assign level_x = XW'(level_q);
	assign min_x   = $signed(XW'(min_q));
	assign minl_x  = (min_x > LVL_MAX) ? LVL_MAX : min_x;
	assign sus_x   = $signed(XW'(sustain_q));
	assign suss_x  = (sus_x > LVL_MAX) ? LVL_MAX : sus_x;

	// base + rounded product, saturated to the level range
	assign v_x   = XW'($signed(base_sel)) + XW'(rnd_q);
	assign v_sat = (v_x > LVL_MAX) ? LVL_MAX : ((v_x < LVL_MIN) ? LVL_MIN : v_x);

	// one digit of the multiplier per cycle; the top digit is signed
	assign last_step = (step_q == CW'(NSTEP - 1));
	assign dig       = r_q[D-1:0];
	assign dig_s     = $signed({last_step & dig[D-1], dig});
	assign pp        = $signed(level_q) * dig_s;
	assign hi_sum    = $signed(r_q[RW-1:NB]) + pp;
	assign r_step    = RW'($signed({hi_sum, r_q[NB-1:0]}) >>> D);

	assign s_rnd = $signed(r_q[LW+SW:LW-2]) + (SW+3)'(r_q[LW-3]);
	assign s_sat = (s_rnd > SMP_MAX) ? SMP_MAX : ((s_rnd < SMP_MIN) ? SMP_MIN : s_rnd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_mult_q  <= '0;
			attack_base_q  <= '0;
			decay_mult_q   <= '0;
			decay_base_q   <= '0;
			sustain_q      <= SUSTAIN_RST;
			release_mult_q <= '0;
			release_base_q <= '0;
			min_q          <= MIN_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ATTACK_MULT:   attack_mult_q  <= cfg_wdata[MULT_W-1:0];
				REG_ATTACK_BASE:   attack_base_q  <= cfg_wdata[BASE_W-1:0];
				REG_DECAY_MULT:    decay_mult_q   <= cfg_wdata[MULT_W-1:0];
				REG_DECAY_BASE:    decay_base_q   <= cfg_wdata[BASE_W-1:0];
				REG_SUSTAIN_LEVEL: sustain_q      <= cfg_wdata[LVLREG_W-1:0];
				REG_RELEASE_MULT:  release_mult_q <= cfg_wdata[MULT_W-1:0];
				REG_RELEASE_BASE:  release_base_q <= cfg_wdata[BASE_W-1:0];
				REG_MIN_LEVEL:     min_q          <= cfg_wdata[LVLREG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			step_q     <= '0;
			phase_q    <= PH_IDLE;
			level_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready && st_q != ST_FIN)
				m_tvalid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						step_q <= '0;
						case (cmd)
							CMD_TICK: begin
								if (phase_q == PH_IDLE) begin
									level_q <= '0;
									st_q    <= ST_FIN;
								end else if (phase_q == PH_SUSTAIN) begin
									r_q  <= {{HW{1'b0}}, NB'($signed(smp_in))};
									st_q <= ST_MUL2;
								end else begin
									r_q  <= RW'(mult_sel);
									st_q <= ST_MUL1;
								end
							end
							CMD_NOTE_ON: begin
								if (level_x < minl_x)
									level_q <= LW'(minl_x);
								phase_q <= PH_ATTACK;
								st_q    <= ST_FIN;
							end
							CMD_NOTE_OFF: begin
								if (phase_q inside {PH_ATTACK, PH_DECAY, PH_SUSTAIN})
									phase_q <= PH_RELEASE;
								st_q <= ST_FIN;
							end
							default: begin
								level_q <= LW'(minl_x);
								st_q    <= ST_FIN;
							end
						endcase
					end
				end
				ST_MUL1: begin
					r_q    <= r_step;
					step_q <= step_q + CW'(1);
					if (last_step)
						st_q <= ST_RND1;
				end
				ST_RND1: begin
					st_q <= ST_UPD;
				end
				ST_UPD: begin
					case (phase_q)
						PH_ATTACK: begin
							if (v_sat >= LVL_ONE) begin
								level_q <= LW'(LVL_ONE);
								phase_q <= PH_DECAY;
							end else begin
								level_q <= LW'(v_sat);
							end
						end
						PH_DECAY: begin
							if (v_sat <= sus_x) begin
								level_q <= LW'(suss_x);
								phase_q <= PH_SUSTAIN;
							end else begin
								level_q <= LW'(v_sat);
							end
						end
						default: begin
							level_q <= LW'(v_sat);
							if (v_sat <= min_x)
								phase_q <= PH_IDLE;
						end
					endcase
					r_q    <= {{HW{1'b0}}, NB'($signed(sample_q))};
					step_q <= '0;
					st_q   <= ST_MUL2;
				end
				ST_MUL2: begin
					r_q    <= r_step;
					step_q <= step_q + CW'(1);
					if (last_step)
						st_q <= ST_RND2;
				end
				ST_RND2: begin
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						st_q       <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= smp_in;
			sout_q   <= '0;
		end
		if (st_q == ST_RND1)
			rnd_q <= $signed(r_q[MULT_FRAC+LW:MULT_FRAC]) + (LW+1)'(r_q[MULT_FRAC-1]);
		if (st_q == ST_RND2)
			sout_q <= SW'(s_sat);
		if (st_q == ST_FIN && out_free)
			m_tdata_q <= OW'({(phase_q != PH_IDLE), phase_q, sout_q, level_q});
	end

endmodule

`default_nettype wire

### sv/adsr_chk.sv
// Port-level checker for the ADSR envelope generator, bound to the top level.
// Depends on adsr_pkg and adsr_envelope_generator_top.
`timescale 1ns / 1ps
`default_nettype none

module adsr_chk
	import adsr_pkg::*;
#(
	parameter int LEVEL_WIDTH  = LEVEL_WIDTH_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input wire logic                                                    clk,
	input wire logic                                                    arst_n,
	input wire logic                                                    s_tvalid,
	input wire logic                                                    s_tready,
	input wire logic                                                    m_tvalid,
	input wire logic                                                    m_tready,
	input wire logic [((LEVEL_WIDTH+SAMPLE_WIDTH+PHASE_W+1+7)/8)*8-1:0] m_tdata
);

	localparam int PH_LO = LEVEL_WIDTH + SAMPLE_WIDTH;

	// stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	// active flag agrees with phase
	a_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[PH_LO+PHASE_W] == (m_tdata[PH_LO+PHASE_W-1:PH_LO] != PH_IDLE)))
		else $error("active flag does not match phase");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in work");

	a_rst_empty: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind adsr_envelope_generator_top adsr_chk #(
	.LEVEL_WIDTH (LEVEL_WIDTH),
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_adsr_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire
